FILE: rtl/core/pixel_color_adjust_core_defines.svh
// ---------------------------------------------------------------------------
// pixel_color_adjust_core_defines
// Assertion macros shared by the pixel color adjust core.
// ---------------------------------------------------------------------------
`ifndef PIXEL_COLOR_ADJUST_CORE_DEFINES_SVH
`define PIXEL_COLOR_ADJUST_CORE_DEFINES_SVH

// same-cycle implication
`define PCA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pca_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pca_pkg
// Constants and types for the pixel color adjust core.
// ---------------------------------------------------------------------------
package pca_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_BRIGHT   = 3'd1,
        CFG_CONTRAST = 3'd2,
        CFG_SAT      = 3'd3,
        CFG_HUE      = 3'd4
    } t_cfg_idx;

    localparam int DIV_DW = 16;
    localparam int DIV_QW = 13;

    localparam logic [15:0] CH_MAX    = 16'd65280;
    localparam logic [12:0] ONE_Q12   = 13'd4096;
    localparam logic [12:0] SEXTANT   = 13'd960;
    localparam logic [12:0] FULL_TURN = 13'd5760;
    localparam logic [15:0] RECIP_15  = 16'd34953;

    typedef logic [2:0] t_sext;

    function automatic logic [12:0] sext_base(input t_sext i);
        logic [12:0] b;
        case (i)
            3'd0:    b = 13'd0;
            3'd1:    b = 13'd960;
            3'd2:    b = 13'd1920;
            3'd3:    b = 13'd2880;
            3'd4:    b = 13'd3840;
            default: b = 13'd4800;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/pca_div_pipe.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pca_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module pca_div_pipe #(
    parameter int DW = 16,
    parameter int QW = 13
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quot,
    output logic [DW-1:0]    o_rem
);
    localparam int CW = DW + QW;

    logic [CW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quot [QW];
    logic [CW-1:0] n_rem  [QW];
    logic [QW-1:0] n_quot [QW];
    logic [CW-1:0] w_rem_in  [QW];
    logic [DW-1:0] w_den_in  [QW];
    logic [QW-1:0] w_quot_in [QW];
    logic [CW-1:0] w_sub     [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        if (j == 0) begin : g_first
            assign w_rem_in[j]  = i_num;
            assign w_den_in[j]  = i_den;
            assign w_quot_in[j] = '0;
        end else begin : g_next
            assign w_rem_in[j]  = r_rem[j-1];
            assign w_den_in[j]  = r_den[j-1];
            assign w_quot_in[j] = r_quot[j-1];
        end

        always_comb begin
            w_sub[j] = CW'(w_den_in[j]) << (QW - 1 - j);
            if (w_rem_in[j] >= w_sub[j]) begin
                n_rem[j]  = w_rem_in[j] - w_sub[j];
                n_quot[j] = w_quot_in[j] | (QW'(1) << (QW - 1 - j));
            end else begin
                n_rem[j]  = w_rem_in[j];
                n_quot[j] = w_quot_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QW; j++) begin
                r_rem[j]  <= n_rem[j];
                r_den[j]  <= w_den_in[j];
                r_quot[j] <= n_quot[j];
            end
        end
    end

    assign o_quot = r_quot[QW-1];
    assign o_rem  = r_rem[QW-1][DW-1:0];

endmodule

FILE: rtl/core/pixel_color_adjust_core.sv
`timescale 1ns / 1ps
// Pipeline: 4 front stages, 13 divider stages and 7 back stages between input
// transfer and output valid. Throughput: one pixel per cycle when not stalled.
// The whole pipeline advances together; it holds while the output is stalled.
// Reset: synchronous, active low; clears valid bits and sets config registers to defaults.
// ---------------------------------------------------------------------------
// pixel_color_adjust_core
// Brightness, contrast, saturation and hue adjustment of RGB888 pixels.
// ---------------------------------------------------------------------------
module pixel_color_adjust_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [23:0]                i_s_axis_tdata,   // red_in, green_in, blue_in
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [23:0]                o_m_axis_tdata,   // red_out, green_out, blue_out
    input  logic                       i_cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pca_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pca_pkg::*;

    localparam int QW = DIV_QW;

    // config
    logic [3:0]         r_mask;
    logic signed [12:0] r_bias;
    logic [11:0]        r_contrast;
    logic [11:0]        r_ratio;
    logic signed [13:0] r_hue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_bias     <= '0;
            r_contrast <= 12'd256;
            r_ratio    <= 12'd256;
            r_hue      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:   r_mask     <= i_cfg_data[3:0];
                CFG_BRIGHT:   r_bias     <= i_cfg_data[12:0];
                CFG_CONTRAST: r_contrast <= i_cfg_data[11:0];
                CFG_SAT:      r_ratio    <= i_cfg_data[11:0];
                CFG_HUE:      r_hue      <= i_cfg_data[13:0];
                default:      ;
            endcase
        end
    end

    logic w_en;
    logic w_hsv;
    logic r_out_vld;
    assign w_en  = !r_out_vld || i_m_axis_tready;
    assign w_hsv = r_mask[2] || r_mask[3];
    assign o_s_axis_tready = w_en;

    // stage 1: brightness
    logic        r_s1_vld;
    logic [15:0] r_s1_c [3];
    logic [15:0] n_s1_c [3];
    logic signed [18:0] w_bsum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_bsum[k] = $signed({3'b000, i_s_axis_tdata[8*k +: 8], 8'h00})
                      + $signed({{2{r_bias[12]}}, r_bias, 4'h0});
            if (!r_mask[0]) begin
                n_s1_c[k] = {i_s_axis_tdata[8*k +: 8], 8'h00};
            end else if (w_bsum[k] < 0) begin
                n_s1_c[k] = '0;
            end else if (w_bsum[k] > $signed({3'b000, CH_MAX})) begin
                n_s1_c[k] = CH_MAX;
            end else begin
                n_s1_c[k] = w_bsum[k][15:0];
            end
        end
    end

    // stage 2: contrast
    logic        r_s2_vld;
    logic [15:0] r_s2_c [3];
    logic [15:0] n_s2_c [3];
    logic signed [17:0] w_cdif [3];
    logic signed [30:0] w_cprod [3];
    logic signed [30:0] w_csum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cdif[k]  = $signed({2'b00, r_s1_c[k]}) - 18'sd32768;
            w_cprod[k] = $signed({1'b0, r_contrast}) * w_cdif[k];
            w_csum[k]  = (w_cprod[k] >>> 8) + 31'sd32768;
            if (!r_mask[1]) begin
                n_s2_c[k] = r_s1_c[k];
            end else if (w_csum[k] < 0) begin
                n_s2_c[k] = '0;
            end else if (w_csum[k] > $signed({15'd0, CH_MAX})) begin
                n_s2_c[k] = CH_MAX;
            end else begin
                n_s2_c[k] = w_csum[k][15:0];
            end
        end
    end

    // stage 3: max, min, sector
    logic               r_s3_vld;
    logic [15:0]        r_s3_mx, r_s3_dl;
    logic signed [16:0] r_s3_num;
    logic [1:0]         r_s3_k;
    logic [23:0]        r_s3_byp;
    logic [15:0]        n_s3_mx, n_s3_mn;
    logic signed [16:0] n_s3_num;
    logic [1:0]         n_s3_k;

    always_comb begin
        n_s3_mx = r_s2_c[0];
        n_s3_mn = r_s2_c[0];
        if (r_s2_c[1] > n_s3_mx) n_s3_mx = r_s2_c[1];
        if (r_s2_c[2] > n_s3_mx) n_s3_mx = r_s2_c[2];
        if (r_s2_c[1] < n_s3_mn) n_s3_mn = r_s2_c[1];
        if (r_s2_c[2] < n_s3_mn) n_s3_mn = r_s2_c[2];
        if (r_s2_c[0] == n_s3_mx) begin
            n_s3_k   = 2'd0;
            n_s3_num = $signed({1'b0, r_s2_c[1]}) - $signed({1'b0, r_s2_c[2]});
        end else if (r_s2_c[1] == n_s3_mx) begin
            n_s3_k   = 2'd1;
            n_s3_num = $signed({1'b0, r_s2_c[2]}) - $signed({1'b0, r_s2_c[0]});
        end else begin
            n_s3_k   = 2'd2;
            n_s3_num = $signed({1'b0, r_s2_c[0]}) - $signed({1'b0, r_s2_c[1]});
        end
    end

    // stage 4: dividends
    logic        r_s4_vld;
    logic [28:0] r_s4_snum, r_s4_hnum;
    logic [15:0] r_s4_mx, r_s4_dl;
    logic        r_s4_neg, r_s4_dz;
    logic [1:0]  r_s4_k;
    logic [23:0] r_s4_byp;
    logic [15:0] w_anum;
    logic [25:0] w_m960;

    assign w_anum = r_s3_num[16] ? 16'(-r_s3_num) : r_s3_num[15:0];
    assign w_m960 = {w_anum, 10'd0} - {4'd0, w_anum, 6'd0};

    // dividers
    logic [QW-1:0]     w_sq, w_hq;
    logic [DIV_DW-1:0] w_srem, w_hrem;

    pca_div_pipe #(.DW(DIV_DW), .QW(QW)) u_div_s (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_s4_snum),
        .i_den  (r_s4_mx),
        .o_quot (w_sq),
        .o_rem  (w_srem)
    );

    pca_div_pipe #(.DW(DIV_DW), .QW(QW)) u_div_h (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_s4_hnum),
        .i_den  (r_s4_dl),
        .o_quot (w_hq),
        .o_rem  (w_hrem)
    );

    logic        r_dl_vld [QW];
    logic        r_dl_neg [QW];
    logic        r_dl_dz  [QW];
    logic [1:0]  r_dl_k   [QW];
    logic [15:0] r_dl_v   [QW];
    logic [23:0] r_dl_byp [QW];

    // stage P1: saturation, hue assembly
    logic        r_p1_vld;
    logic [12:0] r_p1_s, r_p1_h;
    logic [15:0] r_p1_v;
    logic [23:0] r_p1_byp;
    logic [12:0] n_p1_s, n_p1_h;
    logic [13:0]        w_hmag;
    logic signed [13:0] w_hsum;
    logic [24:0]        w_sprod;

    always_comb begin
        w_hmag = {1'b0, w_hq} + ((w_hrem != '0) ? 14'd1 : 14'd0);
        w_hsum = $signed({12'd0, r_dl_k[QW-1]}) * 14'sd1920
               + (r_dl_neg[QW-1] ? -$signed(w_hmag) : $signed({1'b0, w_hq}));
        if (w_hsum < 0) w_hsum = w_hsum + $signed({1'b0, FULL_TURN});
        w_sprod = w_sq * r_ratio;
        if (r_dl_dz[QW-1]) begin
            n_p1_s = '0;
            n_p1_h = '0;
        end else begin
            n_p1_h = w_hsum[12:0];
            if (!r_mask[2]) begin
                n_p1_s = w_sq;
            end else if (w_sprod[24:8] > 17'(ONE_Q12)) begin
                n_p1_s = ONE_Q12;
            end else begin
                n_p1_s = w_sprod[20:8];
            end
        end
    end

    // stage P2: hue rotation
    logic        r_p2_vld;
    logic [12:0] r_p2_s, r_p2_h;
    logic [15:0] r_p2_v;
    logic [23:0] r_p2_byp;
    logic signed [14:0] w_hx;

    always_comb begin
        w_hx = $signed({2'b00, r_p1_h}) + $signed({r_hue[13], r_hue});
        for (int n = 0; n < 2; n++) begin
            if (w_hx < 0) w_hx = w_hx + $signed({2'b00, FULL_TURN});
            if (w_hx >= $signed({2'b00, FULL_TURN})) w_hx = w_hx - $signed({2'b00, FULL_TURN});
        end
    end

    // stage P3: sextant
    logic        r_p3_vld;
    logic [12:0] r_p3_s;
    logic [9:0]  r_p3_rr;
    t_sext       r_p3_i;
    logic [15:0] r_p3_v;
    logic [23:0] r_p3_byp;
    t_sext       n_p3_i;
    logic [12:0] w_rr;

    always_comb begin
        if (r_p2_h >= 13'd4800)      n_p3_i = 3'd5;
        else if (r_p2_h >= 13'd3840) n_p3_i = 3'd4;
        else if (r_p2_h >= 13'd2880) n_p3_i = 3'd3;
        else if (r_p2_h >= 13'd1920) n_p3_i = 3'd2;
        else if (r_p2_h >= SEXTANT)  n_p3_i = 3'd1;
        else                         n_p3_i = 3'd0;
        w_rr = r_p2_h - sext_base(n_p3_i);
    end

    // stage P4: fraction, f = rr*64/15
    logic        r_p4_vld;
    logic [12:0] r_p4_s, r_p4_f;
    t_sext       r_p4_i;
    logic [15:0] r_p4_v;
    logic [23:0] r_p4_byp;
    logic [31:0] w_fprod;

    assign w_fprod = {r_p3_rr, 6'd0} * RECIP_15;

    // stage P5: S*f terms
    logic        r_p5_vld;
    logic [12:0] r_p5_xp, r_p5_xq, r_p5_xt;
    logic        r_p5_sz;
    t_sext       r_p5_i;
    logic [15:0] r_p5_v;
    logic [23:0] r_p5_byp;
    logic [25:0] w_sf, w_sg;

    assign w_sf = r_p4_s * r_p4_f;
    assign w_sg = r_p4_s * (ONE_Q12 - r_p4_f);

    // stage P6: p, q, t
    logic        r_p6_vld;
    logic [15:0] r_p6_p, r_p6_q, r_p6_t;
    logic        r_p6_sz;
    t_sext       r_p6_i;
    logic [15:0] r_p6_v;
    logic [23:0] r_p6_byp;
    logic [28:0] w_pp, w_pq, w_pt;

    assign w_pp = r_p5_v * r_p5_xp;
    assign w_pq = r_p5_v * r_p5_xq;
    assign w_pt = r_p5_v * r_p5_xt;

    // output stage
    logic [23:0] r_out_data;
    logic [23:0] n_out_data;
    logic [7:0]  w_v8, w_p8, w_q8, w_t8;

    always_comb begin
        w_v8 = r_p6_v[15:8];
        w_p8 = r_p6_p[15:8];
        w_q8 = r_p6_q[15:8];
        w_t8 = r_p6_t[15:8];
        if (!w_hsv) begin
            n_out_data = r_p6_byp;
        end else if (r_p6_sz) begin
            n_out_data = {w_v8, w_v8, w_v8};
        end else begin
            case (r_p6_i)
                3'd0:    n_out_data = {w_p8, w_t8, w_v8};
                3'd1:    n_out_data = {w_p8, w_v8, w_q8};
                3'd2:    n_out_data = {w_t8, w_v8, w_p8};
                3'd3:    n_out_data = {w_v8, w_q8, w_p8};
                3'd4:    n_out_data = {w_v8, w_p8, w_t8};
                default: n_out_data = {w_q8, w_p8, w_v8};
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            for (int j = 0; j < QW; j++) r_dl_vld[j] <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld    <= i_s_axis_tvalid;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_dl_vld[0] <= r_s4_vld;
            for (int j = 1; j < QW; j++) r_dl_vld[j] <= r_dl_vld[j-1];
            r_p1_vld    <= r_dl_vld[QW-1];
            r_p2_vld    <= r_p1_vld;
            r_p3_vld    <= r_p2_vld;
            r_p4_vld    <= r_p3_vld;
            r_p5_vld    <= r_p4_vld;
            r_p6_vld    <= r_p5_vld;
            r_out_vld   <= r_p6_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_c <= n_s1_c;
            r_s2_c <= n_s2_c;

            r_s3_mx  <= n_s3_mx;
            r_s3_dl  <= n_s3_mx - n_s3_mn;
            r_s3_num <= n_s3_num;
            r_s3_k   <= n_s3_k;
            r_s3_byp <= {r_s2_c[2][15:8], r_s2_c[1][15:8], r_s2_c[0][15:8]};

            r_s4_snum <= {1'b0, r_s3_dl, 12'd0};
            r_s4_hnum <= {3'd0, w_m960};
            r_s4_mx   <= r_s3_mx;
            r_s4_dl   <= r_s3_dl;
            r_s4_neg  <= r_s3_num[16];
            r_s4_dz   <= (r_s3_dl == '0);
            r_s4_k    <= r_s3_k;
            r_s4_byp  <= r_s3_byp;

            r_dl_neg[0] <= r_s4_neg;
            r_dl_dz[0]  <= r_s4_dz;
            r_dl_k[0]   <= r_s4_k;
            r_dl_v[0]   <= r_s4_mx;
            r_dl_byp[0] <= r_s4_byp;
            for (int j = 1; j < QW; j++) begin
                r_dl_neg[j] <= r_dl_neg[j-1];
                r_dl_dz[j]  <= r_dl_dz[j-1];
                r_dl_k[j]   <= r_dl_k[j-1];
                r_dl_v[j]   <= r_dl_v[j-1];
                r_dl_byp[j] <= r_dl_byp[j-1];
            end

            r_p1_s   <= n_p1_s;
            r_p1_h   <= n_p1_h;
            r_p1_v   <= r_dl_v[QW-1];
            r_p1_byp <= r_dl_byp[QW-1];

            r_p2_s   <= r_p1_s;
            r_p2_h   <= r_mask[3] ? w_hx[12:0] : r_p1_h;
            r_p2_v   <= r_p1_v;
            r_p2_byp <= r_p1_byp;

            r_p3_s   <= r_p2_s;
            r_p3_rr  <= w_rr[9:0];
            r_p3_i   <= n_p3_i;
            r_p3_v   <= r_p2_v;
            r_p3_byp <= r_p2_byp;

            r_p4_s   <= r_p3_s;
            r_p4_f   <= w_fprod[31:19];
            r_p4_i   <= r_p3_i;
            r_p4_v   <= r_p3_v;
            r_p4_byp <= r_p3_byp;

            r_p5_xp  <= ONE_Q12 - r_p4_s;
            r_p5_xq  <= ONE_Q12 - w_sf[24:12];
            r_p5_xt  <= ONE_Q12 - w_sg[24:12];
            r_p5_sz  <= (r_p4_s == '0);
            r_p5_i   <= r_p4_i;
            r_p5_v   <= r_p4_v;
            r_p5_byp <= r_p4_byp;

            r_p6_p   <= w_pp[27:12];
            r_p6_q   <= w_pq[27:12];
            r_p6_t   <= w_pt[27:12];
            r_p6_sz  <= r_p5_sz;
            r_p6_i   <= r_p5_i;
            r_p6_v   <= r_p5_v;
            r_p6_byp <= r_p5_byp;

            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

`include "pixel_color_adjust_core_defines.svh"

    `PCA_ASSERT_IMPL(a_sat_clamp, r_p1_vld, r_p1_s <= ONE_Q12, "saturation above one")
    `PCA_ASSERT_IMPL(a_hue_range, r_p2_vld, r_p2_h < FULL_TURN, "hue out of range")
    `PCA_ASSERT_NEXT(a_stall_hold, !w_en, $stable(r_s4_vld) && $stable(r_p6_vld), "pipe moved in stall")

endmodule

FILE: dv/pixel_color_adjust_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_color_adjust_core_tb
// Self-checking bench for the pixel color adjust core. A queue of pixels
// feeds a clocked driver; a clocked monitor compares each output transfer
// with the pixel predicted in fixed point for the current register setting.
// Phases sweep the register settings, extremes included, and the output side
// is held off for a long stretch once so that the pipeline backs up.
// ---------------------------------------------------------------------------
module pixel_color_adjust_core_tb;
    import pca_pkg::*;

    localparam int LATENCY = 24;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata = '0;  // red, green, blue
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;        // red, green, blue
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pixel_color_adjust_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [3:0]         adj_enable;
    logic signed [12:0] adj_bias;
    logic [11:0]        adj_contrast;
    logic [11:0]        adj_sat;
    logic signed [13:0] adj_hue;

    t_pixel pending_pixels[$];
    t_pixel expected_pixels[$];
    int     mismatches = 0;
    bit     calm = 0;
    bit     hold_off = 0;

    function automatic longint fdiv(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic longint clamp_ch(longint v);
        if (v < 0) return 0;
        if (v > 65280) return 65280;
        return v;
    endfunction

    function automatic longint wrap_turn(longint h);
        if (h < 0) h += 5760;
        if (h >= 5760) h -= 5760;
        return h;
    endfunction

    function automatic t_pixel predict_pixel(t_pixel px);
        longint c[3];
        longint r, g, b, mx, mn, dl, h, s, v, i, f, p, q, t;
        t_pixel o;
        c[0] = longint'(px.red) << 8;
        c[1] = longint'(px.green) << 8;
        c[2] = longint'(px.blue) << 8;
        if (adj_enable[0])
            for (int k = 0; k < 3; k++) c[k] = clamp_ch(c[k] + longint'(adj_bias) * 16);
        if (adj_enable[1])
            for (int k = 0; k < 3; k++)
                c[k] = clamp_ch(fdiv(longint'(adj_contrast) * (c[k] - 32768), 256) + 32768);
        if (adj_enable[3:2] != 0) begin
            r = c[0]; g = c[1]; b = c[2];
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            v = mx; dl = mx - mn; h = 0; s = 0;
            if (dl != 0) begin
                s = (dl * 4096) / mx;
                if (r == mx) h = fdiv(960 * (g - b), dl);
                else if (g == mx) h = 1920 + fdiv(960 * (b - r), dl);
                else h = 3840 + fdiv(960 * (r - g), dl);
                if (h < 0) h += 5760;
            end
            if (adj_enable[2]) begin
                s = (s * longint'(adj_sat)) >>> 8;
                if (s > 4096) s = 4096;
            end
            if (adj_enable[3]) h = wrap_turn(wrap_turn(h + longint'(adj_hue)));
            if (s == 0) begin
                r = v; g = v; b = v;
            end else begin
                i = h / 960;
                f = ((h - i * 960) * 4096) / 960;
                p = (v * (4096 - s)) >>> 12;
                q = (v * (4096 - ((s * f) >>> 12))) >>> 12;
                t = (v * (4096 - ((s * (4096 - f)) >>> 12))) >>> 12;
                case (i)
                    0: begin r = v; g = t; b = p; end
                    1: begin r = q; g = v; b = p; end
                    2: begin r = p; g = v; b = t; end
                    3: begin r = p; g = q; b = v; end
                    4: begin r = t; g = p; b = v; end
                    default: begin r = v; g = p; b = q; end
                endcase
            end
            c[0] = r; c[1] = g; c[2] = b;
        end
        o.red = c[0][15:8];
        o.green = c[1][15:8];
        o.blue = c[2][15:8];
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                    t_pixel px;
                    px = pending_pixels.pop_front();
                    expected_pixels.push_back(predict_pixel(px));
                    i_s_axis_tdata <= px;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 20);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected output %h", o_m_axis_tdata);
                end else begin
                    t_pixel e, a;
                    e = expected_pixels.pop_front();
                    a = o_m_axis_tdata;
                    if (a.red !== e.red || a.green !== e.green || a.blue !== e.blue) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                                     e.red, e.green, e.blue, a.red, a.green, a.blue);
                    end
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:   adj_enable = val[3:0];
            CFG_BRIGHT:   adj_bias = val[12:0];
            CFG_CONTRAST: adj_contrast = val[11:0];
            CFG_SAT:      adj_sat = val[11:0];
            CFG_HUE:      adj_hue = val[13:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_all(int en, int bias, int con, int sat, int hue);
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_BRIGHT, CFG_DATA_W'(bias));
        write_reg(CFG_CONTRAST, CFG_DATA_W'(con));
        write_reg(CFG_SAT, CFG_DATA_W'(sat));
        write_reg(CFG_HUE, CFG_DATA_W'(hue));
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px = 24'($urandom);
        case ($urandom_range(9))
            0: px.green = px.red;
            1: begin px.green = px.red; px.blue = px.red; end
            2: px.blue = px.red;
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        adj_enable = 0; adj_bias = 0; adj_contrast = 256; adj_sat = 256; adj_hue = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, grays, primaries, ties between channels
        set_all(4'hf, 0, 256, 256, 0);
        pending_pixels.push_back(24'h000000);
        pending_pixels.push_back(24'hffffff);
        pending_pixels.push_back(24'h0000ff);
        pending_pixels.push_back(24'h00ff00);
        pending_pixels.push_back(24'hff0000);
        pending_pixels.push_back(24'h808080);
        pending_pixels.push_back(24'h00ffff);
        pending_pixels.push_back(24'hff00ff);
        pending_pixels.push_back(24'hffff00);
        pending_pixels.push_back(24'h123456);
        pending_pixels.push_back(24'h563412);
        pending_pixels.push_back(24'h0155aa);
        drain();
        set_all(4'hf, 4095, 4095, 4095, 5759);
        for (int j = 0; j < 6; j++) pending_pixels.push_back(rand_pixel());
        drain();
        set_all(4'hf, -4096, 0, 0, -5759);
        for (int j = 0; j < 6; j++) pending_pixels.push_back(rand_pixel());
        drain();
        // hue register beyond the stated range needs the second wrap
        set_all(4'h8, 0, 256, 256, 8191);
        for (int j = 0; j < 6; j++) pending_pixels.push_back(rand_pixel());
        drain();

        // random phases, one with a long output hold-off
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: set_all($urandom, $urandom, $urandom, $urandom, $urandom);
                1: set_all($urandom, $urandom_range(8191), $urandom_range(512),
                           $urandom_range(512), $urandom_range(16383));
                2: set_all($urandom, $urandom, $urandom, $urandom,
                           $urandom_range(11518) - 5759);
                default: set_all($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            write_reg(t_cfg_idx'(3'd7), CFG_DATA_W'($urandom));
            calm = (ph == 5);
            for (int j = 0; j < 80; j++) pending_pixels.push_back(rand_pixel());
            if (ph == 9) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            drain();
            calm = 0;
        end

        if (mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pca_pkg.sv
rtl/core/pca_div_pipe.sv
rtl/core/pixel_color_adjust_core.sv
dv/pixel_color_adjust_core_tb.sv
